// File: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/bht_pkg.sv
// Package for the bone hierarchy transform: matrix types and Q16.16 helpers.
// Depends on nothing; used by the top level.
package bht_pkg;

  localparam int ELEM_W    = 32;
  localparam int WORD_W    = 64;
  localparam int WORDS     = 8;
  localparam int ELEMS     = 16;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + 2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef word_t [WORDS-1:0]        mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam elem_t ELEM_MAX = 32'sh7fff_ffff;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;

  // Element e of a row-major matrix; even elements sit in the low half of a word.
  function automatic elem_t get_elem(mat_t m, logic [3:0] e);
    word_t w;
    w = m[e[3:1]];
    return e[0] ? elem_t'(w[63:32]) : elem_t'(w[31:0]);
  endfunction

  // Exact sum of four products, floored by the fraction bits, saturated to 32 bits.
  function automatic elem_t dot4(elem_t l0, elem_t l1, elem_t l2, elem_t l3,
                                 elem_t p0, elem_t p1, elem_t p2, elem_t p3);
    prod_t q0, q1, q2, q3;
    acc_t  acc;
    acc_t  sh;
    elem_t res;
    q0  = prod_t'(l0) * prod_t'(p0);
    q1  = prod_t'(l1) * prod_t'(p1);
    q2  = prod_t'(l2) * prod_t'(p2);
    q3  = prod_t'(l3) * prod_t'(p3);
    acc = acc_t'(q0) + acc_t'(q1) + acc_t'(q2) + acc_t'(q3);
    sh  = acc >>> FRAC_BITS;
    if (sh[ACC_W-1:ELEM_W-1] == '0 || sh[ACC_W-1:ELEM_W-1] == '1) begin
      res = elem_t'(sh[ELEM_W-1:0]);
    end else if (sh[ACC_W-1]) begin
      res = ELEM_MIN;
    end else begin
      res = ELEM_MAX;
    end
    return res;
  endfunction

endpackage

// File: src/bone_hierarchy_transform_top.sv
// Top level of the bone hierarchy transform: input register, bone store, product
// logic and result register. Depends on bht_pkg.
//
// Bones enter in index order at one beat per cycle while the output is not stalled;
// each gives one result beat via the input register and then the result register.
// At acceptance the parent's world row is read from the bone store, one 512-bit row
// per bone; when the parent is the bone written in that same cycle, its world matrix
// is forwarded from a holding register instead. One pass of 64 parallel 32x32
// multipliers, four-term sums, flooring and saturation lies between the input
// register and the result register, so the store's single read port and that pass
// set the rate of one bone per cycle while unstalled. The store holds no meaningful
// data until written; reset does not sweep it but clears the counter and valid flags.
module bone_hierarchy_transform_top #(
  parameter int MAX_BONES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               first_bone,
  input  logic               has_parent,
  input  logic [7:0]         parent_index,
  input  logic signed [63:0] local_0,
  input  logic signed [63:0] local_1,
  input  logic signed [63:0] local_2,
  input  logic signed [63:0] local_3,
  input  logic signed [63:0] local_4,
  input  logic signed [63:0] local_5,
  input  logic signed [63:0] local_6,
  input  logic signed [63:0] local_7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               parent_error,
  output logic signed [63:0] world_0,
  output logic signed [63:0] world_1,
  output logic signed [63:0] world_2,
  output logic signed [63:0] world_3,
  output logic signed [63:0] world_4,
  output logic signed [63:0] world_5,
  output logic signed [63:0] world_6,
  output logic signed [63:0] world_7
);
  import bht_pkg::*;

  localparam int AW   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CW   = $clog2(MAX_BONES + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic [CW-1:0] bone_counter;
  logic [CW-1:0] bone_counter_next;

  logic          s1_v;
  mat_t          s1_local;
  logic          s1_root;
  logic          s1_err;
  logic          s1_store;
  logic [AW-1:0] s1_idx;
  logic          s1_fwd;
  mat_t          rd_row;
  mat_t          last_world;

  logic          out_v;
  logic          out_err;
  mat_t          out_world;

  mat_t          store_mem [MAX_BONES];

  mat_t          in_mat;
  mat_t          parent_mat;
  mat_t          prod_mat;
  mat_t          world_c;
  logic [CW-1:0] idx_c;
  logic          full_c;
  logic          bad_parent_c;
  logic [AW-1:0] rd_addr;
  logic          mv;
  logic          accept;
  logic          wr_en;

  assign in_mat  = {local_7, local_6, local_5, local_4, local_3, local_2, local_1, local_0};
  assign rd_addr = AW'(parent_index);

  assign idx_c        = first_bone ? '0 : bone_counter;
  assign full_c       = idx_c >= CW'(MAX_BONES);
  assign bad_parent_c = has_parent && (CMPW'(parent_index) >= CMPW'(idx_c));
  assign bone_counter_next = full_c ? CW'(MAX_BONES) : idx_c + CW'(1);

  assign mv       = s1_v && (!out_v || !out_stall);
  assign in_stall = rst || (s1_v && !mv);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = mv && s1_store;

  assign parent_mat = s1_fwd ? last_world : rd_row;

  always_comb begin
    elem_t res [ELEMS];
    for (int e = 0; e < ELEMS; e++) begin
      res[e] = dot4(get_elem(s1_local, 4'((e >> 2) * 4 + 0)),
                    get_elem(s1_local, 4'((e >> 2) * 4 + 1)),
                    get_elem(s1_local, 4'((e >> 2) * 4 + 2)),
                    get_elem(s1_local, 4'((e >> 2) * 4 + 3)),
                    get_elem(parent_mat, 4'(0 + (e & 3))),
                    get_elem(parent_mat, 4'(4 + (e & 3))),
                    get_elem(parent_mat, 4'(8 + (e & 3))),
                    get_elem(parent_mat, 4'(12 + (e & 3))));
    end
    for (int w = 0; w < WORDS; w++) begin
      prod_mat[w] = {res[2 * w + 1], res[2 * w]};
    end
  end

  assign world_c = s1_root ? s1_local : prod_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_counter <= '0;
      s1_v         <= 1'b0;
      out_v        <= 1'b0;
    end else begin
      if (accept) begin
        bone_counter <= bone_counter_next;
      end
      if (accept) begin
        s1_v <= 1'b1;
      end else if (mv) begin
        s1_v <= 1'b0;
      end
      if (mv) begin
        out_v <= 1'b1;
      end else if (!out_stall) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_local <= in_mat;
      s1_root  <= !has_parent || full_c || bad_parent_c;
      s1_err   <= full_c || bad_parent_c;
      s1_store <= !full_c;
      s1_idx   <= AW'(idx_c);
      s1_fwd   <= wr_en && (s1_idx == rd_addr);
      rd_row   <= store_mem[rd_addr];
    end
    if (wr_en) begin
      store_mem[s1_idx] <= world_c;
      last_world        <= world_c;
    end
    if (mv) begin
      out_err   <= s1_err;
      out_world <= world_c;
    end
  end

  assign out_valid    = out_v;
  assign parent_error = out_err;
  assign world_0      = out_world[0];
  assign world_1      = out_world[1];
  assign world_2      = out_world[2];
  assign world_3      = out_world[3];
  assign world_4      = out_world[4];
  assign world_5      = out_world[5];
  assign world_6      = out_world[6];
  assign world_7      = out_world[7];

endmodule

// File: src/bht_checker.sv
// Port-level checker for the bone hierarchy transform and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bht_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               parent_error,
  input logic signed [63:0] world_0,
  input logic signed [63:0] world_7
);

  // A stalled result beat stays valid.
  `ASSERT_NEXT(a_out_hold_valid, clk, rst, out_valid && out_stall, out_valid)

  // A stalled result beat keeps its payload.
  `ASSERT_NEXT(a_out_hold_data, clk, rst, out_valid && out_stall, $stable(parent_error) && $stable(world_0) && $stable(world_7))

  // Outside reset, the input side only stalls when a finished beat is held back downstream.
  `ASSERT_IMPLY(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // A result appearing on an idle output comes from a bone that went straight through the input register.
  `ASSERT_IMPLY(a_out_source, clk, rst, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind bone_hierarchy_transform_top bht_checker u_bht_checker (.*);
